// File: design/drrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package drrb_pkg;

  // Default number of angular bins in the scan ring.
  localparam int NUM_BINS_DEF = 360;
  // Widest ring the design supports sets the stored bin field width.
  localparam int BIN_MAX_W    = 12;

  // Port field widths.
  localparam int COL_W        = 12;
  localparam int DISP_W       = 16;
  localparam int BIN_IDX_W    = 9;
  localparam int RANGE_W      = 16;

  // Configuration register widths.
  localparam int FB_W         = 24;
  localparam int BPC_W        = 20;
  localparam int WIDTH_W      = 13;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  // Bin mapping arithmetic: signed column offset times Q4.16 scale, then Q.17 sum.
  localparam int OFF_W        = COL_W + 2;
  localparam int PROD_W       = OFF_W + BPC_W + 1;
  localparam int V_W          = PROD_W + 1;
  localparam int BIN_FRAC_W   = 17;

  // Depth division: focal_baseline * 16 over a positive Q12.4 disparity.
  localparam int DIVIDEND_W   = FB_W + 4;
  localparam int DIVISOR_W    = DISP_W - 1;
  localparam int DIV_STEPS    = 2;
  localparam int DIV_CYCLES   = DIVIDEND_W / DIV_STEPS;
  localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH  = 2;

  // Reset values of the configuration registers.
  localparam logic [FB_W-1:0]    FB_RST    = '0;
  localparam logic [BPC_W-1:0]   BPC_RST   = BPC_W'(6144);
  localparam logic [WIDTH_W-1:0] WIDTH_RST = WIDTH_W'(640);
  localparam logic [RANGE_W-1:0] RMIN_RST  = RANGE_W'(100);
  localparam logic [RANGE_W-1:0] RMAX_RST  = RANGE_W'(5000);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_BASELINE = 3'd0,
    CFG_BINS_PER_COL   = 3'd1,
    CFG_IMAGE_WIDTH    = 3'd2,
    CFG_RANGE_MIN      = 3'd3,
    CFG_RANGE_MAX      = 3'd4
  } cfg_idx_e;

  // Work kinds handed from the front to the back.
  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_READ     = 2'd1,
    OP_READ_OOR = 2'd2
  } op_e;

  typedef struct packed {
    logic [FB_W-1:0]    focal_baseline;
    logic [BPC_W-1:0]   bins_per_col;
    logic [WIDTH_W-1:0] image_width;
    logic [RANGE_W-1:0] clamp_lo;
    logic [RANGE_W-1:0] clamp_hi;
  } cfg_t;

  typedef struct packed {
    op_e                  op;
    logic [BIN_MAX_W-1:0] bin;
    logic [DIVISOR_W-1:0] disp;
    logic [BIN_IDX_W-1:0] out_bin;
    logic                 last;
  } qent_t;

endpackage

`default_nettype wire

// File: design/drrb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module drrb_front
  import drrb_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cfg_t                     cfg_i,
  input  wire logic                     clearing_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     req_type_i,
  input  wire logic [COL_W-1:0]         column_i,
  input  wire logic signed [DISP_W-1:0] disparity_i,
  input  wire logic [BIN_IDX_W-1:0]     bin_index_i,
  output logic                          push_o,
  output qent_t                         push_ent_o,
  input  wire logic                     push_ready_i
);

  typedef enum logic {
    ST_IDLE,
    ST_PUSH
  } state_e;

  localparam logic [V_W-1:0] CenterV = V_W'(NUM_BINS) << (BIN_FRAC_W - 1);

  state_e                   state_q;
  logic                     req_q;
  logic [COL_W-1:0]         col_q;
  logic [DISP_W-1:0]        disp_q;
  logic [BIN_IDX_W-1:0]     bidx_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [OFF_W-1:0]  off;
  logic signed [PROD_W-1:0] prod_d;
  logic [V_W-1:0]           v;
  logic [V_W-BIN_FRAC_W-1:0] v_int;
  logic                     bin_ok;
  logic [BIN_MAX_W-1:0]     bin;
  logic                     col_ok;
  logic                     disp_ok;
  logic                     rd_in_range;
  logic                     accept;
  logic                     need_push;

  assign in_ready_o = (state_q == ST_IDLE) && !clearing_i;
  assign accept     = in_valid_i && in_ready_o;

  // Signed column offset from the row center, scaled by bins per column.
  assign off    = $signed({1'b0, column_i, 1'b0}) - $signed({1'b0, cfg_i.image_width});
  assign prod_d = off * $signed({1'b0, cfg_i.bins_per_col});

  // Bin position in Q.17; truncation toward zero sends (-1, 0) to bin 0.
  assign v     = {prod_q[PROD_W-1], prod_q} + CenterV;
  assign v_int = v[V_W-1:BIN_FRAC_W];
  always_comb begin
    if (v[V_W-1]) begin
      bin_ok = (&v_int) && (|v[BIN_FRAC_W-1:0]);
      bin    = '0;
    end else begin
      bin_ok = v_int < (V_W-BIN_FRAC_W)'(NUM_BINS);
      bin    = v_int[BIN_MAX_W-1:0];
    end
  end

  assign col_ok      = {1'b0, col_q} < cfg_i.image_width;
  assign disp_ok     = (disp_q != '0) && !disp_q[DISP_W-1] && (cfg_i.focal_baseline != '0);
  assign rd_in_range = {{(BIN_MAX_W+1-BIN_IDX_W){1'b0}}, bidx_q} < (BIN_MAX_W+1)'(NUM_BINS);

  // Classify the held item into a queue entry; dropped samples push nothing.
  always_comb begin
    push_ent_o         = '0;
    push_ent_o.out_bin = bidx_q;
    push_ent_o.disp    = disp_q[DIVISOR_W-1:0];
    if (req_q) begin
      push_ent_o.op   = rd_in_range ? OP_READ : OP_READ_OOR;
      push_ent_o.bin  = BIN_MAX_W'(bidx_q);
      push_ent_o.last = rd_in_range &&
                        ({{(BIN_MAX_W+1-BIN_IDX_W){1'b0}}, bidx_q} ==
                         (BIN_MAX_W+1)'(NUM_BINS - 1));
      need_push       = 1'b1;
    end else begin
      push_ent_o.op   = OP_SAMPLE;
      push_ent_o.bin  = bin;
      need_push       = col_ok && bin_ok && disp_ok;
    end
  end

  assign push_o = (state_q == ST_PUSH) && need_push;

  // Capture the item and its product, then hand it on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!need_push || push_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      col_q  <= column_i;
      disp_q <= disparity_i;
      bidx_q <= bin_index_i;
      prod_q <= prod_d;
    end
  end

endmodule

`default_nettype wire

// File: design/drrb_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module drrb_queue
  import drrb_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire qent_t push_ent_i,
  output logic       push_ready_o,
  output logic       pop_valid_o,
  output qent_t      pop_ent_o,
  input  wire logic  pop_i
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  qent_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = cnt_q != CntW'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_ent_o    = slot_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_ent_i;
    end
  end

endmodule

`default_nettype wire

// File: design/drrb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module drrb_back
  import drrb_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_t                  cfg_i,
  output logic                       clearing_o,
  input  wire logic                  pop_valid_i,
  input  wire qent_t                 pop_ent_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [BIN_IDX_W-1:0]       out_bin_o,
  output logic [RANGE_W-1:0]         range_mm_o,
  output logic                       no_return_o,
  output logic                       last_bin_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WRITE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [RANGE_W-1:0] range;
  } bin_ent_t;

  localparam int AddrW = $clog2(NUM_BINS);

  state_e                 state_q;
  qent_t                  ent_q;
  logic [AddrW-1:0]       clr_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic [DIVIDEND_W-1:0]  num_q;
  logic [DIVISOR_W-1:0]   rem_q;
  logic [DIVIDEND_W-1:0]  num_d;
  logic [DIVISOR_W-1:0]   rem_d;
  bin_ent_t               range_mem [NUM_BINS];
  bin_ent_t               rd_data_q;
  logic                   rd_en;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr;
  bin_ent_t               mem_wdata;
  logic [DIVIDEND_W-1:0]  lo_clamped;
  logic [RANGE_W-1:0]     depth;
  logic                   out_free;
  logic                   out_valid_q;
  logic [BIN_IDX_W-1:0]   out_bin_q;
  logic [RANGE_W-1:0]     range_q;
  logic                   no_ret_q;
  logic                   last_q;

  assign clearing_o  = state_q == ST_CLEAR;
  assign pop_o       = (state_q == ST_IDLE) && pop_valid_i;
  assign rd_en       = pop_o && (pop_ent_i.op == OP_READ);
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_bin_o   = out_bin_q;
  assign range_mm_o  = range_q;
  assign no_return_o = no_ret_q;
  assign last_bin_o  = last_q;

  // Two restoring division steps per cycle.
  always_comb begin
    logic [DIVISOR_W:0] trial;
    num_d = num_q;
    rem_d = rem_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_d, num_d[DIVIDEND_W-1]};
      if (trial >= {1'b0, ent_q.disp}) begin
        rem_d = DIVISOR_W'(trial - {1'b0, ent_q.disp});
        num_d = {num_d[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIVISOR_W-1:0];
        num_d = {num_d[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  // Raise the quotient to the minimum, then lower it to the maximum.
  assign lo_clamped = (num_q < DIVIDEND_W'(cfg_i.clamp_lo)) ?
                      DIVIDEND_W'(cfg_i.clamp_lo) : num_q;
  assign depth      = (lo_clamped > DIVIDEND_W'(cfg_i.clamp_hi)) ?
                      cfg_i.clamp_hi : lo_clamped[RANGE_W-1:0];

  // Memory write port: clearing sweep, sample store or clear after readout.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ent_q.bin[AddrW-1:0];
    mem_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_WRITE: begin
        mem_we          = 1'b1;
        mem_wdata.valid = 1'b1;
        mem_wdata.range = depth;
      end
      ST_RESP: begin
        mem_we = out_free && (ent_q.op == OP_READ);
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      range_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= range_mem[pop_ent_i.bin[AddrW-1:0]];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(NUM_BINS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop_valid_i) begin
            cnt_q <= '0;
            if (pop_ent_i.op == OP_SAMPLE) begin
              state_q <= ST_DIV;
            end else begin
              state_q <= ST_RESP;
            end
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state_q <= ST_IDLE;
        end
        ST_RESP: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= pop_ent_i;
      num_q <= {cfg_i.focal_baseline, 4'b0000};
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
    if ((state_q == ST_RESP) && out_free) begin
      out_bin_q <= ent_q.out_bin;
      last_q    <= ent_q.last;
      if (ent_q.op == OP_READ) begin
        no_ret_q <= !rd_data_q.valid;
        range_q  <= rd_data_q.valid ? rd_data_q.range : '0;
      end else begin
        no_ret_q <= 1'b1;
        range_q  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/disparity_row_to_range_bins.sv
`timescale 1ns / 1ps
`default_nettype none

// Turns disparity samples of an image row into a ring of NUM_BINS range bins.
// Input channel (valid/ready): req_type 0 is a sample (column, disparity),
// req_type 1 reads bin_index and clears that bin. Output channel (valid/ready)
// carries one word per readout: out_bin, range_mm, no_return, last_bin.
// Samples produce no output word. Configuration is a plain write port
// (cfg_we_i, cfg_idx_i, cfg_wdata_i); the user must write it only while the
// block is idle, and the block itself does not enforce this. The front
// captures a word and its column product, then classifies it, and takes no
// new word until it is done with the last; a two-entry queue feeds the back.
// The back pops a sample, runs the 28-bit radix-2 divider at 2 bits a cycle,
// and stores the result. For a readout it does a registered memory read, then
// the output register load and the bin clear. A readout word passes the
// front's capture registers, a queue slot and that memory read before
// out_valid_o rises. After reset the back sweeps all NUM_BINS bins (360 by
// default) to no-return, with in_ready_o low meanwhile. When the receiver
// stalls, one finished word waits in the output register; the front keeps
// accepting until the queue is full and it holds one more word itself.
module disparity_row_to_range_bins
  import drrb_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     req_type_i,
  input  wire logic [COL_W-1:0]         column_i,
  input  wire logic signed [DISP_W-1:0] disparity_i,
  input  wire logic [BIN_IDX_W-1:0]     bin_index_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [BIN_IDX_W-1:0]          out_bin_o,
  output logic [RANGE_W-1:0]            range_mm_o,
  output logic                          no_return_o,
  output logic                          last_bin_o
);

  cfg_t  cfg_q;
  logic  clearing;
  logic  push;
  qent_t push_ent;
  logic  push_ready;
  logic  pop_valid;
  qent_t pop_ent;
  logic  pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal_baseline <= FB_RST;
      cfg_q.bins_per_col   <= BPC_RST;
      cfg_q.image_width    <= WIDTH_RST;
      cfg_q.clamp_lo       <= RMIN_RST;
      cfg_q.clamp_hi       <= RMAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FOCAL_BASELINE: cfg_q.focal_baseline <= cfg_wdata_i[FB_W-1:0];
        CFG_BINS_PER_COL:   cfg_q.bins_per_col   <= cfg_wdata_i[BPC_W-1:0];
        CFG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_wdata_i[WIDTH_W-1:0];
        CFG_RANGE_MIN:      cfg_q.clamp_lo       <= cfg_wdata_i[RANGE_W-1:0];
        CFG_RANGE_MAX:      cfg_q.clamp_hi       <= cfg_wdata_i[RANGE_W-1:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  drrb_front #(
    .NUM_BINS(NUM_BINS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clearing_i  (clearing),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .column_i    (column_i),
    .disparity_i (disparity_i),
    .bin_index_i (bin_index_i),
    .push_o      (push),
    .push_ent_o  (push_ent),
    .push_ready_i(push_ready)
  );

  drrb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ent_i  (push_ent),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_ent_o   (pop_ent),
    .pop_i       (pop)
  );

  drrb_back #(
    .NUM_BINS(NUM_BINS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .clearing_o (clearing),
    .pop_valid_i(pop_valid),
    .pop_ent_i  (pop_ent),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_bin_o  (out_bin_o),
    .range_mm_o (range_mm_o),
    .no_return_o(no_return_o),
    .last_bin_o (last_bin_o)
  );

endmodule

`default_nettype wire

// File: design/drrb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module drrb_checker
  import drrb_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic [BIN_IDX_W-1:0] out_bin_o,
  input wire logic [RANGE_W-1:0]   range_mm_o,
  input wire logic                 no_return_o,
  input wire logic                 last_bin_o
);

  // A stalled output word holds its bin and range.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_bin_o) && $stable(range_mm_o))
    else $error("output word changed while stalled");

  // An empty bin reports a zero range.
  a_noret_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_return_o |-> range_mm_o == '0)
    else $error("no-return word with nonzero range");

  // The final-bin flag marks exactly the last bin of the ring.
  a_last_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      last_bin_o == ({{(BIN_MAX_W+1-BIN_IDX_W){1'b0}}, out_bin_o} ==
                     (BIN_MAX_W+1)'(NUM_BINS - 1)))
    else $error("last_bin flag disagrees with out_bin");

  // A bin beyond the ring never carries a range.
  a_oor_noret: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o &&
      ({{(BIN_MAX_W+1-BIN_IDX_W){1'b0}}, out_bin_o} >= (BIN_MAX_W+1)'(NUM_BINS))
      |-> no_return_o)
    else $error("out-of-range bin reported a return");

endmodule

bind disparity_row_to_range_bins drrb_checker #(
  .NUM_BINS(NUM_BINS)
) u_drrb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_bin_o  (out_bin_o),
  .range_mm_o (range_mm_o),
  .no_return_o(no_return_o),
  .last_bin_o (last_bin_o)
);

`default_nettype wire

// File: dv/disparity_row_to_range_bins_test.sv
`timescale 1ns / 1ps

module disparity_row_to_range_bins_test;
  import drrb_pkg::*;

  localparam int          RING_BINS    = NUM_BINS_DEF;
  localparam bit          REQ_SAMPLE   = 1'b0;
  localparam bit          REQ_READOUT  = 1'b1;
  localparam int          PHASE_ITEMS  = 160;
  localparam int          DRAIN_CYCLES = 100;
  localparam int          LONG_HOLD    = 400;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;

  // One readout word as the block reports it.
  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin;
    logic [RANGE_W-1:0]   range_mm;
    logic                 no_return;
    logic                 last_bin;
  } readout_t;

  // Tracks the bin ring and the settings, and holds the readouts still due.
  class range_bin_scoreboard;
    logic [FB_W-1:0]    focal_baseline;
    logic [BPC_W-1:0]   bins_per_col;
    logic [WIDTH_W-1:0] image_width;
    logic [RANGE_W-1:0] clamp_lo;
    logic [RANGE_W-1:0] clamp_hi;
    logic [RANGE_W-1:0] bin_range[RING_BINS];
    bit                 bin_valid[RING_BINS];
    readout_t           readouts_due[$];
    int                 errors;
    int                 results_seen;

    function new();
      focal_baseline = FB_RST;
      bins_per_col   = BPC_RST;
      image_width    = WIDTH_RST;
      clamp_lo       = RMIN_RST;
      clamp_hi       = RMAX_RST;
      foreach (bin_range[i]) begin
        bin_range[i] = '0;
        bin_valid[i] = 1'b0;
      end
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_FOCAL_BASELINE: focal_baseline = value[FB_W-1:0];
        CFG_BINS_PER_COL:   bins_per_col   = value[BPC_W-1:0];
        CFG_IMAGE_WIDTH:    image_width    = value[WIDTH_W-1:0];
        CFG_RANGE_MIN:      clamp_lo       = value[RANGE_W-1:0];
        CFG_RANGE_MAX:      clamp_hi       = value[RANGE_W-1:0];
        default: ;
      endcase
    endfunction

    // Angular bin of a column in Q.17, truncated toward zero; -1 when off the ring.
    function int bin_of_column(int col);
      longint offset;
      longint scaled;
      longint bin;
      offset = 2 * longint'(col) - longint'(image_width);
      scaled = longint'(RING_BINS) * 65536 + offset * longint'(bins_per_col);
      bin    = scaled / 131072;
      if (bin < 0 || bin >= RING_BINS) return -1;
      return int'(bin);
    endfunction

    // Applies one accepted word to the ring; readouts queue their expected word.
    function void note_word(bit req, logic [COL_W-1:0] col, logic [DISP_W-1:0] disp,
                            logic [BIN_IDX_W-1:0] idx);
      int       bin;
      bit [63:0] depth;
      readout_t r;
      if (req == REQ_SAMPLE) begin
        if (col >= image_width) return;
        bin = bin_of_column(int'(col));
        if (bin < 0 || disp == '0 || disp[DISP_W-1] || focal_baseline == '0) return;
        depth = (64'(focal_baseline) * 64'd16) / 64'(disp[DISP_W-2:0]);
        if (depth < clamp_lo) depth = 64'(clamp_lo);
        if (depth > clamp_hi) depth = 64'(clamp_hi);
        bin_range[bin] = depth[RANGE_W-1:0];
        bin_valid[bin] = 1'b1;
        return;
      end
      r.bin = idx;
      if (idx < RING_BINS) begin
        r.range_mm     = bin_valid[idx] ? bin_range[idx] : '0;
        r.no_return    = !bin_valid[idx];
        r.last_bin     = (idx == RING_BINS - 1);
        bin_valid[idx] = 1'b0;
        bin_range[idx] = '0;
      end else begin
        r.range_mm  = '0;
        r.no_return = 1'b1;
        r.last_bin  = 1'b0;
      end
      readouts_due.push_back(r);
    endfunction

    // Compares one delivered readout with the oldest one due.
    function void check_readout(logic [BIN_IDX_W-1:0] bin, logic [RANGE_W-1:0] range_mm,
                                logic no_return, logic last_bin);
      readout_t want;
      results_seen++;
      if (readouts_due.size() == 0) begin
        $error("readout word with nothing due: out_bin %0d", bin);
        errors++;
        return;
      end
      want = readouts_due.pop_front();
      if (bin !== want.bin) begin
        $error("out_bin mismatch: expected %0d, got %0d", want.bin, bin);
        errors++;
      end
      if (range_mm !== want.range_mm) begin
        $error("range_mm mismatch: expected %0d, got %0d", want.range_mm, range_mm);
        errors++;
      end
      if (no_return !== want.no_return) begin
        $error("no_return mismatch: expected %0d, got %0d", want.no_return, no_return);
        errors++;
      end
      if (last_bin !== want.last_bin) begin
        $error("last_bin mismatch: expected %0d, got %0d", want.last_bin, last_bin);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready_o;
  logic                  req_type    = 1'b0;
  logic [COL_W-1:0]      column      = '0;
  logic [DISP_W-1:0]     disparity   = '0;
  logic [BIN_IDX_W-1:0]  bin_index   = '0;
  logic                  out_valid_o;
  logic                  out_ready   = 1'b0;
  logic [BIN_IDX_W-1:0]  out_bin_o;
  logic [RANGE_W-1:0]    range_mm_o;
  logic                  no_return_o;
  logic                  last_bin_o;

  range_bin_scoreboard sb = new();
  int          burst_left  = 0;
  int unsigned cycle_count = 0;

  disparity_row_to_range_bins dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type),
    .column_i    (column),
    .disparity_i (disparity),
    .bin_index_i (bin_index),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_bin_o   (out_bin_o),
    .range_mm_o  (range_mm_o),
    .no_return_o (no_return_o),
    .last_bin_o  (last_bin_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Every delivered readout word is checked at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      sb.check_readout(out_bin_o, range_mm_o, no_return_o, last_bin_o);
    end
  end

  // Receiver: short and long stalls, calm stretches, and two long hold-offs.
  initial begin : output_sink
    int stall_left;
    int calm_left;
    int holds_done;
    int r;
    stall_left = 0;
    calm_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if ((holds_done == 0 && sb.results_seen >= 40) ||
          (holds_done == 1 && sb.results_seen >= 500)) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        out_ready <= 1'b1;
        calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) stall_left = $urandom_range(1, 3);
        else if (r < 28) stall_left = $urandom_range(15, 50);
        else if (r < 30) calm_left = $urandom_range(50, 200);
        out_ready <= (stall_left == 0);
      end
    end
  end

  // Sender gap: mostly none or short, a few long, with bursts of none.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Offers one word, waits for it to be taken, then may idle the input for a random gap.
  task automatic offer(bit req, logic [COL_W-1:0] col, logic [DISP_W-1:0] disp,
                       logic [BIN_IDX_W-1:0] idx);
    int gap;
    in_valid  <= 1'b1;
    req_type  <= req;
    column    <= col;
    disparity <= disp;
    bin_index <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(req, col, disp, idx);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic write_config(cfg_t c);
    write_reg(CFG_FOCAL_BASELINE, CFG_DATA_W'(c.focal_baseline));
    write_reg(CFG_BINS_PER_COL, CFG_DATA_W'(c.bins_per_col));
    write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(c.image_width));
    write_reg(CFG_RANGE_MIN, CFG_DATA_W'(c.clamp_lo));
    write_reg(CFG_RANGE_MAX, CFG_DATA_W'(c.clamp_hi));
    cfg_we <= 1'b0;
  endtask

  // Waits until every readout is in, then lets trailing samples finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.readouts_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    cfg_t              settings[$];
    cfg_t              c;
    int                cols;
    int                r;
    int                b;
    logic [COL_W-1:0]  col;
    logic [DISP_W-1:0] disp;
    logic [BIN_IDX_W-1:0] idx;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The ring is swept clear after reset before the input opens.
    do @(posedge clk_i); while (!in_ready_o);

    // Directed part at the default mapping: 640 columns over bins 150 to 209.
    write_config('{focal_baseline: 24'd120000, bins_per_col: 20'd6144,
                   image_width: 13'd640, clamp_lo: 16'd100, clamp_hi: 16'd5000});
    offer(REQ_SAMPLE, 12'd320, 16'd800, '0);
    offer(REQ_READOUT, '0, '0, 9'd180);
    offer(REQ_READOUT, '0, '0, 9'd180);
    offer(REQ_SAMPLE, 12'd0, 16'd1, '0);        // smallest disparity, clamped high
    offer(REQ_SAMPLE, 12'd639, 16'h7FFF, '0);   // largest disparity, clamped low
    offer(REQ_SAMPLE, 12'd640, 16'd16, '0);     // column past the row
    offer(REQ_SAMPLE, 12'd4095, 16'd16, '0);
    offer(REQ_SAMPLE, 12'd320, 16'd0, '0);      // zero disparity
    offer(REQ_SAMPLE, 12'd320, 16'h8000, '0);   // negative disparities
    offer(REQ_SAMPLE, 12'd320, 16'hFFFF, '0);
    offer(REQ_READOUT, '0, '0, 9'd150);
    offer(REQ_READOUT, '0, '0, 9'd209);
    offer(REQ_READOUT, '0, '0, 9'd180);
    // Two writes to one bin: the later one stays.
    offer(REQ_SAMPLE, 12'd100, 16'd800, '0);
    offer(REQ_SAMPLE, 12'd100, 16'd1600, '0);
    offer(REQ_READOUT, '0, '0, 9'd159);
    offer(REQ_READOUT, '0, '0, 9'd359);
    offer(REQ_READOUT, '0, '0, 9'd360);         // index off the ring
    offer(REQ_READOUT, '0, '0, 9'd511);
    offer(REQ_READOUT, '0, '0, 9'd0);
    drain();

    // Settings for the random phases, the extremes among them.
    settings.push_back('{24'hFFFFFF, 20'hFFFFF, 13'd4096, 16'd0, 16'd65535});
    settings.push_back('{24'd120000, 20'd36864, 13'd640, 16'd100, 16'd5000});
    settings.push_back('{24'd0, 20'd6144, 13'd640, 16'd100, 16'd5000});
    settings.push_back('{24'd2000000, 20'd36864, 13'd640, 16'd3000, 16'd1000});
    settings.push_back('{24'($urandom_range(1, 24'hFFFFFF)), 20'd5760, 13'd4096,
                         16'd0, 16'd65535});
    settings.push_back('{24'd500000, 20'd0, 13'd1, 16'd0, 16'd65535});
    settings.push_back('{24'd500000, 20'd36864, 13'd0, 16'd100, 16'd5000});
    settings.push_back('{24'd100000, 20'd370000, 13'd64, 16'd0, 16'd65535});
    settings.push_back('{24'd1, 20'd20000, 13'd2000, 16'd0, 16'd65535});
    settings.push_back('{24'hFFFFFF, 20'd36864, 13'd640, 16'd65535, 16'd65535});
    repeat (2) begin
      settings.push_back('{24'($urandom_range(0, 24'hFFFFFF)),
                           20'($urandom_range(0, 20'hFFFFF)),
                           13'($urandom_range(1, 4096)),
                           16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535))});
    end

    foreach (settings[p]) begin
      c = settings[p];
      write_config(c);
      cols = (c.image_width > 4096) ? 4096 : int'(c.image_width);
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          // Sample: mostly inside the row with a positive disparity.
          if ($urandom_range(0, 99) < 85 && cols > 0) col = COL_W'($urandom_range(0, cols - 1));
          else col = COL_W'($urandom_range(0, 4095));
          r = $urandom_range(0, 99);
          if (r < 50) disp = DISP_W'($urandom_range(1, 16'h7FFF));
          else if (r < 80) disp = DISP_W'($urandom_range(1, 255));
          else disp = DISP_W'($urandom_range(0, 16'hFFFF));
          offer(REQ_SAMPLE, col, disp, '0);
        end else begin
          // Readout: mostly a bin that samples of this row can reach.
          r = $urandom_range(0, 99);
          if (r < 65) begin
            b = sb.bin_of_column($urandom_range(0, (cols > 0 ? cols : 1) - 1));
            idx = (b < 0) ? BIN_IDX_W'($urandom_range(0, RING_BINS - 1)) : BIN_IDX_W'(b);
          end else if (r < 88) begin
            idx = BIN_IDX_W'($urandom_range(0, RING_BINS - 1));
          end else begin
            idx = BIN_IDX_W'($urandom_range(RING_BINS, 511));
          end
          offer(REQ_READOUT, COL_W'($urandom_range(0, 4095)),
                DISP_W'($urandom_range(0, 16'hFFFF)), idx);
        end
      end
      drain();
    end

    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
design/drrb_pkg.sv
design/drrb_front.sv
design/drrb_queue.sv
design/drrb_back.sv
design/disparity_row_to_range_bins.sv
design/drrb_checker.sv
dv/disparity_row_to_range_bins_test.sv
